FILE: sv/mbeg_pkg.sv
// ----------------------------------------------------------------------------
// mbeg_pkg
// Shared types and constants of the mel band edge generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mbeg_pkg;

  localparam int unsigned MaxFft = 65536;

  // 2595*log10(2) in Q16
  localparam logic [25:0] MEL_K    = 26'd51194943;
  // floor(2^56 / MEL_K): reciprocal for the mel to log2 step
  localparam logic [31:0] MEL_RECIP = 32'd1407513903;
  localparam logic [9:0]  HZ_BASE  = 10'd700;
  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [4:0]  IP_MAX   = 5'd20;

  // last index of the root table and of the log squaring loop (27 entries / steps)
  localparam logic [4:0]  LAST_ROOT = 5'd26;
  localparam logic [4:0]  LAST_LOG  = 5'd26;

  // divider step counts, sized to the numerator bound of each use
  localparam logic [5:0]  OFF_STEPS = 6'd38;
  localparam logic [5:0]  NUM_STEPS = 6'd52;

  typedef enum logic [2:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_FFT_LENGTH  = 3'd1,
    REG_BAND_COUNT  = 3'd2,
    REG_LOW_FREQ    = 3'd3,
    REG_HIGH_FREQ   = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_ROOT,
    ST_IDLE,
    ST_LOG_INIT,
    ST_LOG_STEP,
    ST_MEL,
    ST_SPAN,
    ST_OFF_START,
    ST_OFF_WAIT,
    ST_T_START,
    ST_T_WAIT,
    ST_POW,
    ST_P_MUL,
    ST_HZ,
    ST_NUM_START,
    ST_NUM_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [5:0] steps;
  } div_req_t;

endpackage

`default_nettype wire

FILE: sv/mbeg_div.sv
// ----------------------------------------------------------------------------
// mbeg_div
// Restoring divider, one quotient bit per cycle. The numerator is given
// left aligned so that only the requested number of steps is run.
// ----------------------------------------------------------------------------
`default_nettype none

module mbeg_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mbeg_pkg::div_req_t req,
  input  wire logic [63:0]       num,
  input  wire logic [33:0]       den,
  output logic                   busy,
  output logic [63:0]            quo,
  output logic [33:0]            rem
);

  logic [5:0]  count;
  logic [33:0] den_q;
  logic [34:0] trial;
  logic [34:0] diff;
  logic        fits;

  assign trial = {rem, quo[63]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= req.steps;
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[62:0], fits};
      rem <= fits ? diff[33:0] : trial[33:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mel_band_edge_generator_unit.sv
// ----------------------------------------------------------------------------
// mel_band_edge_generator_unit
// HTK mel band edge generator: emits band_count+1 FFT bin edges per valid start.
// ----------------------------------------------------------------------------
//  channel    | handshake                    | payload
//  -----------+------------------------------+-------------------------------
//  request    | start, busy                  | request_id
//  config     | cfg_valid, cfg_ready         | cfg_index, cfg_data
//  result     | result_valid (1-cycle pulse) | request_tag, edge_number,
//             |                              | bin_index, is_last, is_error
//
// After reset the root table 2^(2^-k) is built by a bit-serial square root
// with busy high. A request then keeps busy high while its edges are
// computed on the shared one-bit-per-cycle divider (two divisions per edge)
// and the shared 34x32 multiplier loops.
// An invalid configuration gives one error transfer the cycle after start.
// Results cannot be stalled; busy stays high until the last edge is out.
// ----------------------------------------------------------------------------
`default_nettype none

module mel_band_edge_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  request_id,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  output logic             result_valid,
  output logic [7:0]       request_tag,
  output logic [5:0]       edge_number,
  output logic [15:0]      bin_index,
  output logic             is_last,
  output logic             is_error
);

  // configuration
  logic [17:0] rate_hz;
  logic [16:0] fft_length;
  logic [5:0]  band_count;
  logic [16:0] low_freq_hz;
  logic [16:0] high_freq_hz;

  mbeg_pkg::state_t state, state_next;

  // root table build
  logic [31:0] roots [0:26];
  logic [63:0] rv, rr, rbit;
  logic [4:0]  rstep, rk;
  logic [64:0] r_sum;
  logic        r_ge;
  logic [63:0] rv_n, rr_n;

  // log2
  logic [1:0]  log_sel;
  logic [17:0] n_sel;
  logic [16:0] hi_hz;
  logic [4:0]  e_val, e_reg;
  logic [47:0] m_wide;
  logic [31:0] m;
  logic [26:0] frac;
  logic [4:0]  lcnt;
  logic [31:0] log700, mel_low, mel_high, d_log;
  logic [33:0] sq_s;
  logic        sq_top;

  // per edge
  logic        neg;
  logic [31:0] mag;
  logic [5:0]  idx;
  logic [7:0]  tag;
  logic [31:0] mel_pt;
  logic [31:0] ta, t_fix;
  logic [55:0] t_rem;
  logic        t_up;
  logic [4:0]  ip;
  logic [26:0] fbits;
  logic [31:0] acc;
  logic [4:0]  kc;
  logic [41:0] p;
  logic [33:0] hz;
  logic [15:0] prev;
  logic [63:0] hz_full;

  // shared multiplier
  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] mul_p;

  // divider
  mbeg_pkg::div_req_t div_req;
  logic [63:0] div_num;
  logic [33:0] div_den;
  logic        div_busy;
  logic [63:0] quo;
  logic [33:0] rem;

  // edge result
  logic        config_ok;
  logic [15:0] half;
  logic [16:0] twohalf;
  logic [33:0] sr_den;
  logic [34:0] r2;
  logic        round_up;
  logic [63:0] q_r;
  logic [15:0] b_clamp, b_final;
  logic [16:0] prev_inc;

  assign cfg_ready = 1'b1;
  assign busy      = (state != mbeg_pkg::ST_IDLE);

  assign half    = fft_length[16:1];
  assign twohalf = {fft_length[16:1], 1'b0};
  assign sr_den  = {rate_hz, 16'd0};
  assign hi_hz   = (high_freq_hz != 17'd0) ? high_freq_hz : rate_hz[17:1];
  assign config_ok = (rate_hz != 18'd0) && (fft_length >= 17'd2) &&
                     (fft_length <= 17'(mbeg_pkg::MaxFft)) && (band_count != 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz      <= 18'd16000;
      fft_length   <= 17'd512;
      band_count   <= 6'd32;
      low_freq_hz  <= '0;
      high_freq_hz <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (mbeg_pkg::cfg_reg_t'(cfg_index))
        mbeg_pkg::REG_SAMPLE_RATE: rate_hz      <= cfg_data;
        mbeg_pkg::REG_FFT_LENGTH:  fft_length   <= cfg_data[16:0];
        mbeg_pkg::REG_BAND_COUNT:  band_count   <= cfg_data[5:0];
        mbeg_pkg::REG_LOW_FREQ:    low_freq_hz  <= cfg_data[16:0];
        mbeg_pkg::REG_HIGH_FREQ:   high_freq_hz <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // one square root step
  assign r_sum = {1'b0, rr} + {1'b0, rbit};
  assign r_ge  = {1'b0, rv} >= r_sum;
  assign rv_n  = r_ge ? (rv - r_sum[63:0]) : rv;
  assign rr_n  = r_ge ? ((rr >> 1) + rbit) : (rr >> 1);

  // log2 set-up: leading one and normalized mantissa
  always_comb begin
    case (log_sel)
      2'd0:    n_sel = {8'd0, mbeg_pkg::HZ_BASE};
      2'd1:    n_sel = {8'd0, mbeg_pkg::HZ_BASE} + {1'b0, low_freq_hz};
      default: n_sel = {8'd0, mbeg_pkg::HZ_BASE} + {1'b0, hi_hz};
    endcase
    e_val = '0;
    for (int b = 0; b < 18; b++) begin
      if (n_sel[b]) begin
        e_val = 5'(b);
      end
    end
    m_wide = 48'(n_sel) << (5'd30 - e_val);
  end

  assign sq_s   = mul_p[63:30];
  assign sq_top = sq_s[31];
  assign d_log  = {e_reg, frac} - log700;

  // reciprocal estimate is exact or one low; the remainder check settles it
  assign t_rem = {mel_pt, 24'd0} - mul_p[55:0];
  assign t_up  = t_rem >= 56'(mbeg_pkg::MEL_K);
  assign t_fix = ta + 32'(t_up);

  assign hz_full = (64'(p) << ip) - (64'(mbeg_pkg::HZ_BASE) << 30);

  always_comb begin
    case (state)
      mbeg_pkg::ST_LOG_STEP:  begin mul_a = {2'd0, m};   mul_b = m; end
      mbeg_pkg::ST_MEL:       begin mul_a = {2'd0, d_log}; mul_b = {6'd0, mbeg_pkg::MEL_K}; end
      mbeg_pkg::ST_OFF_START: begin mul_a = {2'd0, mag}; mul_b = {26'd0, idx}; end
      mbeg_pkg::ST_T_START:   begin mul_a = {2'd0, mel_pt}; mul_b = mbeg_pkg::MEL_RECIP; end
      mbeg_pkg::ST_T_WAIT:    begin mul_a = {2'd0, ta};  mul_b = {6'd0, mbeg_pkg::MEL_K}; end
      mbeg_pkg::ST_POW:       begin mul_a = {2'd0, acc}; mul_b = roots[kc]; end
      mbeg_pkg::ST_P_MUL:     begin mul_a = {2'd0, acc}; mul_b = {22'd0, mbeg_pkg::HZ_BASE}; end
      mbeg_pkg::ST_NUM_START: begin mul_a = hz;          mul_b = {15'd0, twohalf}; end
      default:                begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding to nearest even, clamp, and the forced rise over the last edge
  assign r2       = {rem, 1'b0};
  assign round_up = (r2 > {1'b0, sr_den}) || ((r2 == {1'b0, sr_den}) && quo[0]);
  assign q_r      = quo + 64'(round_up);
  assign b_clamp  = (q_r > 64'(half)) ? half : q_r[15:0];
  assign prev_inc = {1'b0, prev} + 17'd1;
  always_comb begin
    b_final = b_clamp;
    if ((idx != 6'd0) && (b_clamp <= prev)) begin
      b_final = (prev_inc < {1'b0, half}) ? prev_inc[15:0] : half;
    end
  end

  mbeg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (quo),
    .rem  (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbeg_pkg::ST_ROOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_req.start = 1'b0;
    div_req.steps = mbeg_pkg::OFF_STEPS;
    div_num       = {mul_p[37:0], 26'd0};
    div_den       = {28'd0, band_count};
    case (state)
      mbeg_pkg::ST_ROOT: begin
        if ((rstep == 5'd31) && (rk == mbeg_pkg::LAST_ROOT)) begin
          state_next = mbeg_pkg::ST_IDLE;
        end
      end
      mbeg_pkg::ST_IDLE: begin
        if (start && config_ok) begin
          state_next = mbeg_pkg::ST_LOG_INIT;
        end
      end
      mbeg_pkg::ST_LOG_INIT: state_next = mbeg_pkg::ST_LOG_STEP;
      mbeg_pkg::ST_LOG_STEP: begin
        if (lcnt == mbeg_pkg::LAST_LOG) begin
          state_next = mbeg_pkg::ST_MEL;
        end
      end
      mbeg_pkg::ST_MEL: begin
        state_next = (log_sel == 2'd2) ? mbeg_pkg::ST_SPAN : mbeg_pkg::ST_LOG_INIT;
      end
      mbeg_pkg::ST_SPAN: state_next = mbeg_pkg::ST_OFF_START;
      mbeg_pkg::ST_OFF_START: begin
        div_req.start = 1'b1;
        state_next    = mbeg_pkg::ST_OFF_WAIT;
      end
      mbeg_pkg::ST_OFF_WAIT: begin
        if (!div_busy) begin
          state_next = mbeg_pkg::ST_T_START;
        end
      end
      mbeg_pkg::ST_T_START: state_next = mbeg_pkg::ST_T_WAIT;
      mbeg_pkg::ST_T_WAIT:  state_next = mbeg_pkg::ST_POW;
      mbeg_pkg::ST_POW: begin
        if (kc == mbeg_pkg::LAST_ROOT) begin
          state_next = mbeg_pkg::ST_P_MUL;
        end
      end
      mbeg_pkg::ST_P_MUL: state_next = mbeg_pkg::ST_HZ;
      mbeg_pkg::ST_HZ:    state_next = mbeg_pkg::ST_NUM_START;
      mbeg_pkg::ST_NUM_START: begin
        div_req.start = 1'b1;
        div_req.steps = mbeg_pkg::NUM_STEPS;
        div_num       = {mul_p[51:0], 12'd0};
        div_den       = sr_den;
        state_next    = mbeg_pkg::ST_NUM_WAIT;
      end
      mbeg_pkg::ST_NUM_WAIT: begin
        if (!div_busy) begin
          state_next = mbeg_pkg::ST_EMIT;
        end
      end
      mbeg_pkg::ST_EMIT: begin
        state_next = (idx == band_count) ? mbeg_pkg::ST_IDLE : mbeg_pkg::ST_OFF_START;
      end
      default: state_next = mbeg_pkg::ST_IDLE;
    endcase
  end

  // root table build
  always_ff @(posedge clk) begin
    if (rst) begin
      rv    <= 64'd1 << 61;
      rr    <= '0;
      rbit  <= 64'd1 << 62;
      rstep <= '0;
      rk    <= '0;
    end else if (state == mbeg_pkg::ST_ROOT) begin
      if (rstep == 5'd31) begin
        roots[rk] <= rr_n[31:0];
        rv        <= rr_n << 30;
        rr        <= '0;
        rbit      <= 64'd1 << 62;
        rstep     <= '0;
        rk        <= rk + 5'd1;
      end else begin
        rv    <= rv_n;
        rr    <= rr_n;
        rbit  <= rbit >> 2;
        rstep <= rstep + 5'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mbeg_pkg::ST_IDLE: begin
        log_sel <= 2'd0;
        tag     <= request_id;
      end
      mbeg_pkg::ST_LOG_INIT: begin
        e_reg <= e_val;
        m     <= m_wide[31:0];
        frac  <= '0;
        lcnt  <= '0;
      end
      mbeg_pkg::ST_LOG_STEP: begin
        m    <= sq_top ? sq_s[32:1] : sq_s[31:0];
        frac <= {frac[25:0], sq_top};
        lcnt <= lcnt + 5'd1;
      end
      mbeg_pkg::ST_MEL: begin
        case (log_sel)
          2'd0:    log700   <= {e_reg, frac};
          2'd1:    mel_low  <= mul_p[55:24];
          default: mel_high <= mul_p[55:24];
        endcase
        log_sel <= log_sel + 2'd1;
      end
      mbeg_pkg::ST_SPAN: begin
        neg  <= mel_high < mel_low;
        mag  <= (mel_high < mel_low) ? (mel_low - mel_high) : (mel_high - mel_low);
        idx  <= '0;
        prev <= '0;
      end
      mbeg_pkg::ST_OFF_WAIT: begin
        mel_pt <= neg ? (mel_low - quo[31:0]) : (mel_low + quo[31:0]);
      end
      mbeg_pkg::ST_T_START: ta <= mul_p[63:32];
      mbeg_pkg::ST_T_WAIT: begin
        ip    <= (t_fix[31:27] > mbeg_pkg::IP_MAX) ? mbeg_pkg::IP_MAX : t_fix[31:27];
        fbits <= t_fix[26:0];
        acc   <= mbeg_pkg::ONE_Q30;
        kc    <= '0;
      end
      mbeg_pkg::ST_POW: begin
        if (fbits[26]) begin
          acc <= mul_p[61:30];
        end
        fbits <= {fbits[25:0], 1'b0};
        kc    <= kc + 5'd1;
      end
      mbeg_pkg::ST_P_MUL: p <= mul_p[41:0];
      mbeg_pkg::ST_HZ:    hz <= hz_full[47:14];
      mbeg_pkg::ST_EMIT: begin
        prev <= b_final;
        idx  <= idx + 6'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == mbeg_pkg::ST_EMIT) ||
                      ((state == mbeg_pkg::ST_IDLE) && start && !config_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mbeg_pkg::ST_EMIT) begin
      request_tag <= tag;
      edge_number <= idx;
      bin_index   <= b_final;
      is_last     <= (idx == band_count);
      is_error    <= 1'b0;
    end else if ((state == mbeg_pkg::ST_IDLE) && start && !config_ok) begin
      request_tag <= request_id;
      edge_number <= '0;
      bin_index   <= '0;
      is_last     <= 1'b1;
      is_error    <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_error) |-> is_last)
    else $error("error transfer without is_last");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_last && !is_error) |-> !busy)
    else $error("busy after final edge");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !is_last) |-> busy)
    else $error("sequencer idle before final edge");

  a_div_idle_at_emit: assert property (@(posedge clk) disable iff (rst)
    (state == mbeg_pkg::ST_EMIT) |-> !div_busy)
    else $error("edge emitted while divider running");
`endif

endmodule

`default_nettype wire
